@@ rtl/core/assert_macros.svh @@
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms for the transport stream checker core.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/tscc_pkg.sv @@
// ============================================================================
// tscc_pkg
// Types and constants of the transport stream continuity checker.
// ============================================================================
`default_nettype none

package tscc_pkg;

    // Table geometry.
    localparam int PID_ENTRIES_DEFAULT = 8192;
    localparam int ENTRY_W             = 5;
    localparam int CC_W                = 4;

    // Header constants.
    localparam logic [7:0] SYNC_VALUE = 8'h47;

    // Command codes.
    localparam logic [1:0] CMD_PACKET     = 2'd0;
    localparam logic [1:0] CMD_READ_ERR   = 2'd1;
    localparam logic [1:0] CMD_READ_SCR   = 2'd2;
    localparam logic [1:0] CMD_READ_PKT   = 2'd3;

    // One input transfer.
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] sync_byte;
        logic [7:0] pid_high_byte;
        logic [7:0] pid_low_byte;
        logic [7:0] flags_byte;
    } t_in_item;

    // One result transfer.
    typedef struct packed {
        logic [31:0] read_value;
        logic        packet_accepted;
        logic        continuity_error;
        logic        scrambled_flag;
    } t_out_item;

endpackage

`default_nettype wire

@@ rtl/core/tscc_ram.sv @@
// ============================================================================
// tscc_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
`default_nettype none

module tscc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; the data holds while no read is enabled.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ts_continuity_checker_core.sv @@
// ============================================================================
// ts_continuity_checker_core
// Continuity counter check and packet statistics for transport stream headers.
// ============================================================================
// The input channel carries either the four header bytes of one packet or a
// read-and-clear command for one of the error, scrambled and packet totals.
// Every input transfer yields exactly one result transfer, in order.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low.
// Each item passes through the table stage register and then the output
// register before its result is offered on the output channel.
// Throughput: one item per cycle while the output is not stalled. Each header
// does a read-modify-write of the expected counter table; the registered read
// of the table memory is covered by forwarding the most recent write, so
// back-to-back headers on one PID are handled at full rate.
// When the receiver stalls, the result waits in the output register and one
// more item can still enter the table stage; after that the input stalls.
// Reset: the totals clear at once, then a clearing pass writes every table
// entry to unseen, one entry per cycle, through all PID_ENTRIES entries. The
// input is stalled during that pass.
// ============================================================================
`default_nettype none

`include "assert_macros.svh"

module ts_continuity_checker_core #(
    parameter int PID_ENTRIES = tscc_pkg::PID_ENTRIES_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire tscc_pkg::t_in_item  i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output tscc_pkg::t_out_item      o_out_data
);

    localparam int IDX_W = $clog2(PID_ENTRIES);
    localparam int EW    = tscc_pkg::ENTRY_W;
    localparam int CW    = tscc_pkg::CC_W;

    // Clearing pass state.
    logic             r_clr_active;
    logic [IDX_W-1:0] r_clr_addr;

    // Table stage.
    logic                r_s1_valid;
    tscc_pkg::t_in_item  r_s1_item;
    logic [IDX_W-1:0]    r_s1_idx;

    // Forwarding of the latest table write.
    logic             r_fwd_valid;
    logic [IDX_W-1:0] r_fwd_addr;
    logic [EW-1:0]    r_fwd_data;

    // Totals.
    logic [31:0] r_err_total;
    logic [31:0] r_scr_total;
    logic [31:0] r_pkt_total;

    // Output register.
    logic                r_out_valid;
    tscc_pkg::t_out_item r_out_data;

    logic             in_accept;
    logic             s1_move;
    logic [12:0]      in_pid;
    logic [IDX_W-1:0] in_idx;
    logic [EW-1:0]    ram_rd_data;
    logic [EW-1:0]    entry;
    logic             is_pkt;
    logic [CW-1:0]    pkt_cc;
    logic             pkt_err;
    logic             pkt_scr;
    logic [EW-1:0]    new_entry;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [EW-1:0]    wr_data;
    tscc_pkg::t_out_item n_out_data;

    // Handshake control.
    assign s1_move     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_clr_active || (r_s1_valid && !s1_move);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Table index of the incoming header.
    assign in_pid = {i_in_data.pid_high_byte[4:0], i_in_data.pid_low_byte};
    assign in_idx = in_pid[IDX_W-1:0];

    // Entry of the item in the table stage, with the last write forwarded.
    assign entry = (r_fwd_valid && (r_fwd_addr == r_s1_idx)) ? r_fwd_data : ram_rd_data;

    // Header evaluation.
    assign is_pkt    = (r_s1_item.command == tscc_pkg::CMD_PACKET)
                    && (r_s1_item.sync_byte == tscc_pkg::SYNC_VALUE);
    assign pkt_cc    = r_s1_item.flags_byte[CW-1:0];
    assign pkt_scr   = r_s1_item.flags_byte[7];
    assign pkt_err   = entry[EW-1] && (entry[CW-1:0] != pkt_cc);
    assign new_entry = {1'b1, CW'(pkt_cc + CW'(1))};

    // Table write port: the clearing pass, or the write-back of a header.
    always_comb begin
        if (r_clr_active) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = s1_move && is_pkt;
            wr_addr = r_s1_idx;
            wr_data = new_entry;
        end
    end

    tscc_ram #(
        .WIDTH (EW),
        .DEPTH (PID_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (in_accept),
        .i_rd_addr (in_idx),
        .o_rd_data (ram_rd_data)
    );

    // Result of the item in the table stage.
    always_comb begin
        n_out_data = '0;
        unique case (r_s1_item.command)
            tscc_pkg::CMD_READ_ERR: n_out_data.read_value = r_err_total;
            tscc_pkg::CMD_READ_SCR: n_out_data.read_value = r_scr_total;
            tscc_pkg::CMD_READ_PKT: n_out_data.read_value = r_pkt_total;
            default: begin
                n_out_data.packet_accepted  = is_pkt;
                n_out_data.continuity_error = is_pkt && pkt_err;
                n_out_data.scrambled_flag   = is_pkt && pkt_scr;
            end
        endcase
    end

    // Clearing pass after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + IDX_W'(1);
            if (r_clr_addr == IDX_W'(PID_ENTRIES - 1)) begin
                r_clr_active <= 1'b0;
            end
        end
    end

    // Table stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item <= i_in_data;
            r_s1_idx  <= in_idx;
        end
    end

    // Forwarding register follows every header write-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (wr_en && !r_clr_active) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && !r_clr_active) begin
            r_fwd_addr <= wr_addr;
            r_fwd_data <= wr_data;
        end
    end

    // Totals: read commands clear, headers count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_total <= '0;
            r_scr_total <= '0;
            r_pkt_total <= '0;
        end else if (s1_move) begin
            unique case (r_s1_item.command)
                tscc_pkg::CMD_READ_ERR: r_err_total <= '0;
                tscc_pkg::CMD_READ_SCR: r_scr_total <= '0;
                tscc_pkg::CMD_READ_PKT: r_pkt_total <= '0;
                default: begin
                    if (is_pkt) begin
                        r_pkt_total <= r_pkt_total + 32'd1;
                        if (pkt_scr) begin
                            r_scr_total <= r_scr_total + 32'd1;
                        end
                        if (pkt_err) begin
                            r_err_total <= r_err_total + 32'd1;
                        end
                    end
                end
            endcase
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_data <= n_out_data;
        end
    end

    // No input transfer is taken while the table is being cleared.
    `ASSERT_SAME(a_no_accept_in_clear, i_clk, i_rst_n, r_clr_active, !in_accept)
    // An item held in the table stage by a stalled output stays there.
    `ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n, r_s1_valid && !s1_move, r_s1_valid)
    // An error is only reported for an accepted packet.
    `ASSERT_SAME(a_err_needs_pkt, i_clk, i_rst_n,
                 o_out_valid && o_out_data.continuity_error, o_out_data.packet_accepted)

endmodule

`default_nettype wire
